// ===== src/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg - shared types and constants for the min-heap priority queue
// Key, command and status codes, the token that walks down the level
// cells, the write bus between neighboring cells and level sizing helpers.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int unsigned HPQ_CAPACITY = 1024;
   localparam int unsigned HPQ_KEY_W    = 32;
   // sized for the largest supported capacity (65536 entries, 17 levels)
   localparam int unsigned HPQ_IDX_W    = 17;
   localparam int unsigned HPQ_POS_W    = 16;
   localparam int unsigned HPQ_LVL_W    = 5;

   typedef logic signed [HPQ_KEY_W-1:0] key_type;
   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_PEEK   = 2'd1;
   localparam cmd_type CMD_POP    = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SIFT   = 1'b1;

   // insert: pos is the node on the target path at the receiving level
   // sift:   pos is the hole at the level above the receiving cell
   typedef struct packed {
      logic                 valid;
      logic                 op;
      key_type              val;
      logic [HPQ_POS_W-1:0] pos;
      logic [HPQ_IDX_W-1:0] path;   // remaining path bits, next one at the MSB
      logic [HPQ_LVL_W-1:0] hops;   // levels left below this one to the target
   } tok_type;

   typedef struct packed {
      logic                 valid;
      logic [HPQ_POS_W-1:0] addr;
      key_type              data;
   } wr_type;

   typedef struct packed {
      logic                 valid;
      logic [HPQ_LVL_W-1:0] lvl;
      logic [HPQ_POS_W-1:0] pos;
   } fetch_type;

   function automatic int unsigned hpq_addr_w(input int unsigned depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // number of heap nodes that can live on a level for a given capacity
   function automatic int unsigned hpq_lvl_depth(input int unsigned level,
                                                 input int unsigned capacity);
      int unsigned full;
      int unsigned first;
      full  = 1 << level;
      first = full - 1;
      if (capacity - first >= full) begin
         return full;
      end
      return capacity - first;
   endfunction

endpackage

// ===== src/hpq_req_if.sv =====
// ----------------------------------------------------------------------------
// hpq_req_if - command channel of the priority queue
// Valid/ready handshake carrying a command and a key.
// ----------------------------------------------------------------------------
interface hpq_req_if;
   import hpq_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   key_type value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);

endinterface

// ===== src/hpq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hpq_rsp_if - result channel of the priority queue
// Valid/ready handshake carrying the current minimum and a status code.
// ----------------------------------------------------------------------------
interface hpq_rsp_if;
   import hpq_pkg::*;

   logic       valid;
   logic       ready;
   key_type    min_value;
   status_type status;

   modport source (output valid, output min_value, output status, input ready);
   modport sink   (input valid, input min_value, input status, output ready);

endinterface

// ===== src/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue - binary min-heap of signed 32-bit keys
// Root kept in a register, every deeper level in a cell with its own RAM.
//
//   channel   dir   transaction payload
//   req_chan  in    cmd (insert / peek / pop), value
//   rsp_chan  out   min_value, status (ok / empty / full)
//
// One command at a time; in each level cell the token passes a RAM read,
// then a compare. A pop ends early when the moved key settles early.
// Reset clears the entry count and the control registers; the level RAMs are not cleared.
// A result waiting in the output register blocks only the next result.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
   parameter int unsigned CAPACITY = hpq_pkg::HPQ_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   hpq_req_if.sink     req_chan,
   hpq_rsp_if.source   rsp_chan
);
   import hpq_pkg::*;

   localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
   localparam int unsigned LW     = $clog2(LEVELS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_FWAIT = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]         state_ff;
   logic [LEVELS-1:0]  count_ff;
   logic [LW-1:0]      lvl_ff;
   key_type            root_ff;
   logic               full_ff;
   tok_type            tok0_ff;
   logic [LW-1:0]      fl_lvl_ff;
   logic [HPQ_POS_W-1:0] fl_pos_ff;
   logic               rsp_valid_ff;
   key_type            rsp_min_ff;
   status_type         rsp_stat_ff;

   logic [2:0]         state_in;
   logic [LEVELS-1:0]  count_in;
   logic [LW-1:0]      lvl_in;
   key_type            root_in;
   logic               full_in;
   tok_type            tok0_in;
   logic [LW-1:0]      fl_lvl_in;
   logic [HPQ_POS_W-1:0] fl_pos_in;
   logic               rsp_valid_in;
   key_type            rsp_min_in;
   status_type         rsp_stat_in;

   tok_type            tok_a [LEVELS];
   wr_type             up_a  [1:LEVELS-1];
   key_type            fdata [LEVELS];
   logic [LEVELS-1:0]  fin_v;
   fetch_type          fetch;

   logic               accept;
   logic [LEVELS:0]    c0;
   logic [LEVELS:0]    c1;
   logic [LEVELS:0]    c2;
   logic [LEVELS-1:0]  t1;
   logic [HPQ_IDX_W-1:0] path0;
   logic [LW-1:0]      lvl_dn;
   logic [LEVELS-1:0]  last_pos;
   logic               ins_lt;
   status_type         done_stat;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      c0       = {1'b0, count_ff};
      c1       = c0 + 1'b1;
      c2       = c0 + 2'd2;
      t1       = count_ff + 1'b1;
      path0    = HPQ_IDX_W'(t1) << (HPQ_LVL_W'(HPQ_IDX_W - 1) - HPQ_LVL_W'(lvl_ff));
      // level shrinks when the removed entry was the last slot of a full level
      lvl_dn   = ((c1 & c0) == '0) ? lvl_ff - 1'b1 : lvl_ff;
      last_pos = (count_ff - 1'b1) - ((LEVELS'(1) << lvl_dn) - 1'b1);
      ins_lt   = (req_chan.value < root_ff);
      if (full_ff) begin
         done_stat = ST_FULL;
      end else if (count_ff == '0) begin
         done_stat = ST_EMPTY;
      end else begin
         done_stat = ST_OK;
      end
      fetch.valid = (state_ff == S_FETCH);
      fetch.lvl   = HPQ_LVL_W'(fl_lvl_ff);
      fetch.pos   = fl_pos_ff;
   end

   assign fin_v[0] = 1'b0;
   assign fdata[0] = '0;
   assign tok_a[0] = tok0_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lvl_in       = lvl_ff;
      root_in      = root_ff;
      full_in      = full_ff;
      tok0_in      = '0;
      fl_lvl_in    = fl_lvl_ff;
      fl_pos_in    = fl_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               full_in  = 1'b0;
               state_in = S_DONE;
               unique case (req_chan.cmd)
                  CMD_INSERT: begin
                     if (count_ff == LEVELS'(CAPACITY)) begin
                        full_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if ((c2 & c1) == '0) begin
                           lvl_in = lvl_ff + 1'b1;
                        end
                        if (count_ff == '0) begin
                           root_in = req_chan.value;
                        end else begin
                           root_in       = ins_lt ? req_chan.value : root_ff;
                           tok0_in.valid = 1'b1;
                           tok0_in.op    = OP_INSERT;
                           tok0_in.val   = ins_lt ? root_ff : req_chan.value;
                           tok0_in.pos   = HPQ_POS_W'(path0[HPQ_IDX_W-2]);
                           tok0_in.path  = path0 << 2;
                           tok0_in.hops  = HPQ_LVL_W'(lvl_ff) - 1'b1;
                           state_in      = S_RUN;
                        end
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                        lvl_in   = lvl_dn;
                        if (count_ff != LEVELS'(1)) begin
                           fl_lvl_in = lvl_dn;
                           fl_pos_in = HPQ_POS_W'(last_pos);
                           state_in  = S_FETCH;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            // last entry becomes the hole filler at the root
            tok0_in.valid = 1'b1;
            tok0_in.op    = OP_SIFT;
            tok0_in.val   = fdata[fl_lvl_ff];
            tok0_in.pos   = '0;
            tok0_in.path  = '0;
            tok0_in.hops  = '0;
            state_in      = S_RUN;
         end
         S_RUN: begin
            if (|fin_v) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = done_stat;
               rsp_min_in   = (done_stat == ST_OK) ? root_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (up_a[1].valid) begin
         root_in = up_a[1].data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         lvl_ff       <= '0;
         full_ff      <= 1'b0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lvl_ff       <= lvl_in;
         full_ff      <= full_in;
         tok0_ff      <= tok0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff     <= root_in;
      fl_lvl_ff   <= fl_lvl_in;
      fl_pos_ff   <= fl_pos_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.min_value = rsp_min_ff;
   assign rsp_chan.status    = rsp_stat_ff;

   for (genvar k = 1; k < LEVELS; k++) begin : g_level
      if (k < LEVELS - 1) begin : g_mid
         hpq_cell #(
            .LEVEL    (k),
            .LEVELS   (LEVELS),
            .CAPACITY (CAPACITY)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_i   (tok_a[k-1]),
            .tok_o   (tok_a[k]),
            .up_i    (up_a[k+1]),
            .up_o    (up_a[k]),
            .fetch_i (fetch),
            .fetch_o (fdata[k]),
            .count_i (count_ff),
            .fin_o   (fin_v[k])
         );
      end else begin : g_last
         hpq_cell #(
            .LEVEL    (k),
            .LEVELS   (LEVELS),
            .CAPACITY (CAPACITY)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_i   (tok_a[k-1]),
            .tok_o   (tok_a[k]),
            .up_i    ('0),
            .up_o    (up_a[k]),
            .fetch_i (fetch),
            .fetch_o (fdata[k]),
            .count_i (count_ff),
            .fin_o   (fin_v[k])
         );
      end
   end

endmodule

// ===== src/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram - generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module hpq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [hpq_pkg::hpq_addr_w(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [hpq_pkg::hpq_addr_w(DEPTH)-1:0]    rd_a_addr,
   output logic [WIDTH-1:0]                         rd_a_data,
   input  logic [hpq_pkg::hpq_addr_w(DEPTH)-1:0]    rd_b_addr,
   output logic [WIDTH-1:0]                         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== src/hpq_cell.sv =====
// ----------------------------------------------------------------------------
// hpq_cell - one heap level
// Holds the nodes of its level in a RAM. Insert tokens walk the path to the
// new slot, keeping the smaller key here and passing the larger one down.
// Sift tokens carry a hole on the level above: this cell reads both children,
// fills the hole through the up bus and moves the hole down if needed.
// ----------------------------------------------------------------------------
module hpq_cell #(
   parameter int unsigned LEVEL    = 1,
   parameter int unsigned LEVELS   = 11,
   parameter int unsigned CAPACITY = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  hpq_pkg::tok_type    tok_i,
   output hpq_pkg::tok_type    tok_o,
   input  hpq_pkg::wr_type     up_i,
   output hpq_pkg::wr_type     up_o,
   input  hpq_pkg::fetch_type  fetch_i,
   output hpq_pkg::key_type    fetch_o,
   input  logic [LEVELS-1:0]   count_i,
   output logic                fin_o
);
   import hpq_pkg::*;

   localparam int unsigned DEPTH   = hpq_lvl_depth(LEVEL, CAPACITY);
   localparam int unsigned AW      = hpq_addr_w(DEPTH);
   localparam bit          IS_LAST = (LEVEL == LEVELS - 1);
   localparam logic [LEVELS-1:0] BASE = LEVELS'((1 << LEVEL) - 1);

   logic                 pend_ff;
   tok_type              tk_ff;
   tok_type              tok_o_ff;
   tok_type              nxt;
   wr_type               own;
   wr_type               wr;

   logic [HPQ_POS_W-1:0] in_cl;
   logic [HPQ_POS_W-1:0] in_cr;
   logic [HPQ_POS_W-1:0] cl;
   logic [HPQ_POS_W-1:0] cr;
   logic [LEVELS-1:0]    gl;
   logic [LEVELS-1:0]    gr;
   logic                 use_l;
   logic                 use_r;
   key_type              cand;
   key_type              rd_a;
   key_type              rd_b;
   logic [AW-1:0]        rd_a_addr;
   logic [AW-1:0]        rd_b_addr;

   // read addresses come straight from the arriving token or the fetch bus
   always_comb begin
      in_cl = {tok_i.pos[HPQ_POS_W-2:0], 1'b0};
      in_cr = {tok_i.pos[HPQ_POS_W-2:0], 1'b1};
      if (fetch_i.valid && fetch_i.lvl == HPQ_LVL_W'(LEVEL)) begin
         rd_a_addr = fetch_i.pos[AW-1:0];
      end else if (tok_i.op == OP_SIFT) begin
         rd_a_addr = in_cl[AW-1:0];
      end else begin
         rd_a_addr = tok_i.pos[AW-1:0];
      end
      rd_b_addr = in_cr[AW-1:0];
   end

   always_comb begin
      cl    = {tk_ff.pos[HPQ_POS_W-2:0], 1'b0};
      cr    = {tk_ff.pos[HPQ_POS_W-2:0], 1'b1};
      gl    = BASE + LEVELS'(cl);
      gr    = BASE + LEVELS'(cr);
      nxt   = '0;
      own   = '0;
      up_o  = '0;
      fin_o = 1'b0;
      use_l = 1'b0;
      use_r = 1'b0;
      cand  = tk_ff.val;
      if (pend_ff) begin
         if (tk_ff.op == OP_SIFT) begin
            use_l = (gl < count_i) && (rd_a < tk_ff.val);
            cand  = use_l ? rd_a : tk_ff.val;
            use_r = (gr < count_i) && (rd_b < cand);
            up_o.valid = 1'b1;
            up_o.addr  = tk_ff.pos;
            if (use_l || use_r) begin
               up_o.data = use_r ? rd_b : rd_a;
               if (IS_LAST) begin
                  own.valid = 1'b1;
                  own.addr  = use_r ? cr : cl;
                  own.data  = tk_ff.val;
                  fin_o     = 1'b1;
               end else begin
                  nxt.valid = 1'b1;
                  nxt.op    = OP_SIFT;
                  nxt.pos   = use_r ? cr : cl;
                  nxt.val   = tk_ff.val;
               end
            end else begin
               up_o.data = tk_ff.val;
               fin_o     = 1'b1;
            end
         end else if (tk_ff.hops == '0) begin
            own.valid = 1'b1;
            own.addr  = tk_ff.pos;
            own.data  = tk_ff.val;
            fin_o     = 1'b1;
         end else begin
            // keep the smaller key on the path, push the larger one down
            own.valid = (tk_ff.val < rd_a);
            own.addr  = tk_ff.pos;
            own.data  = tk_ff.val;
            nxt.valid = !IS_LAST;
            nxt.op    = OP_INSERT;
            nxt.val   = (tk_ff.val < rd_a) ? rd_a : tk_ff.val;
            nxt.pos   = {tk_ff.pos[HPQ_POS_W-2:0], tk_ff.path[HPQ_IDX_W-1]};
            nxt.path  = tk_ff.path << 1;
            nxt.hops  = tk_ff.hops - 1'b1;
         end
      end
      wr = own.valid ? own : up_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         tok_o_ff <= '0;
      end else begin
         pend_ff  <= tok_i.valid;
         tok_o_ff <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_i.valid) begin
         tk_ff <= tok_i;
      end
   end

   hpq_ram #(
      .WIDTH (HPQ_KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr.valid),
      .wr_addr   (wr.addr[AW-1:0]),
      .wr_data   (wr.data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b)
   );

   assign tok_o   = tok_o_ff;
   assign fetch_o = rd_a;

endmodule
